// ===== hw/rtl/rspp_pkg.sv =====
// Package: types and constants of the rate-shaping packet pacer.
package rspp_pkg;
    localparam int QUEUE_DEPTH      = 64;
    localparam int PTR_W            = $clog2(QUEUE_DEPTH);
    localparam int CNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_PACKET_BYTES = 1500;

    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_FB   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [2:0] REG_INITIAL_RATE = 3'd0;
    localparam logic [2:0] REG_MIN_RATE     = 3'd1;
    localparam logic [2:0] REG_MAX_RATE     = 3'd2;
    localparam logic [2:0] REG_FRAME_RATE   = 3'd3;
    localparam logic [2:0] REG_GAIN_VIDEO   = 3'd4;
    localparam logic [2:0] REG_GAIN_SEND    = 3'd5;
    localparam logic [2:0] REG_BUFFER_EN    = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] packet_bytes;
        logic [47:0] now_us;
        logic [31:0] reference_rate;
    } t_req;

    typedef struct packed {
        logic        send_scheduled;
        logic [31:0] send_delay_us;
        logic [11:0] sent_bytes;
        logic [31:0] video_rate;
        logic [31:0] pacing_rate;
        logic [17:0] queued_bytes;
        logic [1:0]  status;
    } t_rsp;
endpackage

// ===== hw/rtl/rate_shaping_packet_pacer.sv =====
// Top level: size queue memory, pacing sequencer and rate feedback.
//
//   channel | handshake         | payload
//   request | start / busy      | i_req (t_req)
//   result  | o_valid strobe    | o_rsp (t_rsp)
//   config  | i_cfg_valid/ready | i_cfg_index, i_cfg_data
//
// An enqueue, a send on an empty queue or an unknown command passes S_READ, S_EXEC
// and S_DONE before its result strobes; a feedback adds S_FB2, and a send with data
// waits in S_DIV on the bit-serial divider. busy falls with the strobe, so the next
// request can be accepted in the result cycle. The queue memory read is registered.
// Synchronous active-low reset clears pointers, count and totals and loads default rates.
// Results last one cycle and cannot be stalled; busy holds requests off.
module rate_shaping_packet_pacer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rspp_pkg::t_req       i_req,
    output logic                 o_valid,
    output rspp_pkg::t_rsp       o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import rspp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_FB2, S_DONE} t_state;

    t_state r_state;
    t_req   r_req;
    logic [11:0] mem [QUEUE_DEPTH];
    logic [11:0] r_rd;
    logic [PTR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_count;
    logic [17:0] r_total;
    logic [47:0] r_next;
    logic [31:0] r_enc, r_snd;
    logic [31:0] r_min, r_max;
    logic [7:0]  r_fr;
    logic [15:0] r_gv, r_gs;
    logic        r_ben;
    logic        r_sched;
    logic [31:0] r_delay;
    logic [11:0] r_sent;
    logic [1:0]  r_status;
    logic [28:0] r_drain;
    logic [44:0] r_pv, r_ps;
    logic [31:0] r_cap;
    logic        r_div_go;
    logic        w_div_done;
    logic [34:0] w_quot;
    logic [11:0] w_pkt;
    logic [63:0] w_cap_prod;
    logic [31:0] w_intv, w_vsel, w_dsel, w_lo;
    logic [32:0] w_sum;
    logic [47:0] w_owed;
    logic [48:0] w_nsum;
    logic [36:0] w_dv, w_ds;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign w_pkt = (r_req.packet_bytes > 12'(MAX_PACKET_BYTES)) ?
                   12'(MAX_PACKET_BYTES) : r_req.packet_bytes;
    // rate / 20 as (rate / 4) / 5, the divide by 5 through its reciprocal
    assign w_cap_prod = 64'({2'b00, r_req.reference_rate[31:2]}) * 64'(32'hCCCC_CCCD);
    assign w_dv   = r_pv[44:8];
    assign w_ds   = r_ps[44:8];
    assign w_vsel = (w_dv > {5'd0, r_cap}) ? r_cap : w_dv[31:0];
    assign w_dsel = (w_ds > {5'd0, r_cap}) ? r_cap : w_ds[31:0];
    assign w_lo   = r_req.reference_rate - w_vsel;
    assign w_sum  = {1'b0, r_req.reference_rate} + {1'b0, w_dsel};
    assign w_owed = (r_req.now_us < r_next) ? r_next - r_req.now_us : 48'd0;
    assign w_intv = (r_snd == 32'd0 || w_quot[34:32] != 3'd0) ? 32'hFFFF_FFFF : w_quot[31:0];
    assign w_nsum = {1'b0, r_req.now_us} + {17'd0, w_intv};

    rspp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (35'(r_rd) * 35'd8000000),
        .i_den   (r_snd),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_req.command == CMD_ENQ && r_count != CNT_W'(QUEUE_DEPTH))
            mem[r_tail] <= w_pkt;
        r_rd <= mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_head <= '0; r_tail <= '0; r_count <= '0;
            r_total <= '0; r_next <= '0; r_enc <= 32'd1000000; r_snd <= 32'd1000000;
            r_min <= 32'd150000; r_max <= 32'd1500000;
            r_fr <= 8'd30; r_gv <= 16'd256; r_gs <= 16'd256; r_ben <= 1'b1;
            o_valid <= 1'b0; r_div_go <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_INITIAL_RATE: begin
                        r_enc <= i_cfg_data; r_snd <= i_cfg_data;
                    end
                    REG_MIN_RATE:   r_min <= i_cfg_data;
                    REG_MAX_RATE:   r_max <= i_cfg_data;
                    REG_FRAME_RATE: r_fr  <= i_cfg_data[7:0];
                    REG_GAIN_VIDEO: r_gv  <= i_cfg_data[15:0];
                    REG_GAIN_SEND:  r_gs  <= i_cfg_data[15:0];
                    REG_BUFFER_EN:  r_ben <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_req <= i_req; r_sched <= 1'b0; r_delay <= '0;
                    r_sent <= '0; r_status <= ST_OK;
                    r_state <= S_READ;
                end
                S_READ: begin
                    // memory read data for head is valid next cycle
                    r_drain <= (r_count > CNT_W'(1)) ? 29'({r_total, 3'd0}) * 29'(r_fr) : '0;
                    r_cap   <= 32'(w_cap_prod[63:34]);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (r_req.command)
                        CMD_ENQ: if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            r_status <= ST_DROP;
                        end else begin
                            r_tail  <= (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                                       r_tail + PTR_W'(1);
                            r_count <= r_count + CNT_W'(1);
                            r_total <= r_total + 18'(w_pkt);
                            if (!r_ben) begin
                                r_sched <= 1'b1;
                            end else if (r_count == '0) begin
                                r_sched <= 1'b1;
                                r_delay <= (w_owed[47:32] != 16'd0) ? 32'hFFFF_FFFF : w_owed[31:0];
                            end
                        end
                        CMD_SEND: if (r_count == '0) begin
                            r_status <= ST_EMPTY;
                        end else begin
                            r_head  <= (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                                       r_head + PTR_W'(1);
                            r_count <= r_count - CNT_W'(1);
                            r_total <= (r_total >= 18'(r_rd)) ? r_total - 18'(r_rd) : '0;
                            r_sent  <= r_rd;
                            r_div_go <= 1'b1;
                            r_state <= S_DIV;
                        end
                        CMD_FB: begin
                            r_pv <= 45'(r_drain) * 45'(r_gv);
                            r_ps <= 45'(r_drain) * 45'(r_gs);
                            r_state <= S_FB2;
                        end
                        default: ;
                    endcase
                end
                S_DIV: if (w_div_done) begin
                    if (!r_ben || r_count == '0) begin
                        r_next <= w_nsum[48] ? 48'hFFFF_FFFF_FFFF : w_nsum[47:0];
                    end else begin
                        r_sched <= 1'b1;
                        r_delay <= w_intv;
                    end
                    r_state <= S_DONE;
                end
                S_FB2: begin
                    if (r_ben) begin
                        r_enc <= (r_min > w_lo) ? r_min : w_lo;
                        r_snd <= (w_sum > {1'b0, r_max}) ? r_max : w_sum[31:0];
                    end else begin
                        r_enc <= r_req.reference_rate;
                        r_snd <= r_req.reference_rate;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_rsp.send_scheduled = r_sched;
        o_rsp.send_delay_us  = r_delay;
        o_rsp.sent_bytes     = r_sent;
        o_rsp.video_rate     = r_enc;
        o_rsp.pacing_rate    = r_snd;
        o_rsp.queued_bytes   = r_total;
        o_rsp.status         = r_status;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_busy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0)) else $error("bytes on empty queue");
endmodule

// ===== hw/rtl/rspp_div.sv =====
// Iterative restoring divider: 35-bit dividend by 32-bit divisor, one bit a cycle.
module rspp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [34:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [34:0] o_quot
);
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [34:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [32:0] w_sh;
    logic [33:0] w_diff;

    assign w_sh   = {r_rem[31:0], r_q[34]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd35;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[33]) begin
                    r_rem <= w_diff[32:0];
                    r_q   <= {r_q[33:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[33:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== tb/rate_shaping_packet_pacer_tb.sv =====
// Self-checking bench of the rate-shaping packet pacer: queue, pacing and rate feedback.
module rate_shaping_packet_pacer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rspp_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 64;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_valid;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    rate_shaping_packet_pacer i_dut (.*);

    always #6 i_clk = ~i_clk;

    // shadow pacer state and registers
    logic [11:0] sizes_q [QUEUE_DEPTH];
    int          rd_ptr, wr_ptr, fill;
    logic [17:0] total_bytes;
    logic [47:0] release_time;
    logic [31:0] enc_rate, snd_rate;
    logic [31:0] r_init, r_min, r_max;
    logic [7:0]  r_fps;
    logic [15:0] r_gv, r_gs;
    logic        r_shape;

    t_req  pending_reqs[$];
    t_rsp  expected_rsps[$];
    int    errors = 0, cycles = 0, n_enq = 0, n_send = 0, n_fb = 0, n_drop = 0;
    int    gap = 0;
    logic  hold_for_drain = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic post_req(input t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    task automatic pacer_reset_state();
        rd_ptr = 0; wr_ptr = 0; fill = 0; total_bytes = 0; release_time = 0;
        r_init = 1000000; r_min = 150000; r_max = 1500000; r_fps = 30;
        r_gv = 256; r_gs = 256; r_shape = 1'b1;
        enc_rate = r_init; snd_rate = r_init;
    endtask

    function automatic t_rsp pace_step(input t_req rq);
        t_rsp r;
        logic [11:0] pkt;
        logic [63:0] owed, interval, drain, cap, dv, ds, lo, hi, sum;
        r = '0;
        case (rq.command)
            CMD_ENQ: begin
                if (fill >= QUEUE_DEPTH) begin
                    r.status = ST_DROP;
                end else begin
                    pkt = (rq.packet_bytes > MAX_PACKET_BYTES) ? 12'(MAX_PACKET_BYTES)
                                                               : rq.packet_bytes;
                    sizes_q[wr_ptr] = pkt;
                    wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
                    fill++;
                    total_bytes = total_bytes + pkt;
                    if (!r_shape) begin
                        r.send_scheduled = 1'b1;
                    end else if (fill == 1) begin
                        owed = (rq.now_us < release_time) ? 64'(release_time - rq.now_us) : 0;
                        r.send_scheduled = 1'b1;
                        r.send_delay_us = (owed > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : owed[31:0];
                    end
                end
            end
            CMD_SEND: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pkt = sizes_q[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
                    fill--;
                    total_bytes = (total_bytes >= pkt) ? total_bytes - pkt : 0;
                    r.sent_bytes = pkt;
                    if (snd_rate == 0) interval = 64'hFFFF_FFFF;
                    else interval = (64'(pkt) * 64'd8000000) / 64'(snd_rate);
                    if (interval > 64'hFFFF_FFFF) interval = 64'hFFFF_FFFF;
                    if (!r_shape || fill == 0) begin
                        sum = 64'(rq.now_us) + interval;
                        release_time = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[47:0];
                    end else begin
                        r.send_scheduled = 1'b1;
                        r.send_delay_us = interval[31:0];
                    end
                end
            end
            CMD_FB: begin
                if (r_shape) begin
                    drain = 64'd8 * ((fill > 1) ? 64'(total_bytes) : 64'd0) * 64'(r_fps);
                    cap = 64'(rq.reference_rate) / 20;
                    dv = (64'(r_gv) * drain) >> 8;
                    ds = (64'(r_gs) * drain) >> 8;
                    if (dv > cap) dv = cap;
                    if (ds > cap) ds = cap;
                    lo = 64'(rq.reference_rate) - dv;
                    hi = 64'(rq.reference_rate) + ds;
                    enc_rate = (lo < 64'(r_min)) ? r_min : lo[31:0];
                    snd_rate = (hi > 64'(r_max)) ? r_max : hi[31:0];
                end else begin
                    enc_rate = rq.reference_rate;
                    snd_rate = rq.reference_rate;
                end
            end
            default: ;
        endcase
        r.video_rate = enc_rate;
        r.pacing_rate = snd_rate;
        r.queued_bytes = total_bytes;
        return r;
    endfunction

    // driver: one request per handshake, random gaps between requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_rsps.insert(expected_rsps.size(), pace_step(i_req));
            case (i_req.command)
                CMD_ENQ:  n_enq++;
                CMD_SEND: n_send++;
                default:  n_fb++;
            endcase
            pending_reqs.delete(0);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap == 0 && pending_reqs.size() != 0 &&
                (!hold_for_drain || expected_rsps.size() == 0)) begin
                i_req <= pending_reqs[0];
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap > 0) gap--;
            else if (pending_reqs.size() != 0 &&
                     (!hold_for_drain || expected_rsps.size() == 0)) begin
                start <= 1'b1;
                i_req <= pending_reqs[0];
            end
        end
    end

    // monitor: compare every strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        cycles++;
        if (i_rst_n && o_valid) begin
            if (expected_rsps.size() == 0) begin
                report("unexpected result", 64'(o_rsp.status), 0);
            end else begin
                want = expected_rsps[0];
                expected_rsps.delete(0);
                if (want.status == ST_DROP) n_drop++;
                if (o_rsp.send_scheduled !== want.send_scheduled)
                    report("send_scheduled", o_rsp.send_scheduled, want.send_scheduled);
                if (o_rsp.send_delay_us !== want.send_delay_us)
                    report("send_delay_us", o_rsp.send_delay_us, want.send_delay_us);
                if (o_rsp.sent_bytes !== want.sent_bytes)
                    report("sent_bytes", o_rsp.sent_bytes, want.sent_bytes);
                if (o_rsp.video_rate !== want.video_rate)
                    report("video_rate", o_rsp.video_rate, want.video_rate);
                if (o_rsp.pacing_rate !== want.pacing_rate)
                    report("pacing_rate", o_rsp.pacing_rate, want.pacing_rate);
                if (o_rsp.queued_bytes !== want.queued_bytes)
                    report("queued_bytes", o_rsp.queued_bytes, want.queued_bytes);
                if (o_rsp.status !== want.status)
                    report("status", o_rsp.status, want.status);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rate_shaping_packet_pacer verification failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_INITIAL_RATE: begin r_init = val; enc_rate = val; snd_rate = val; end
            REG_MIN_RATE:     r_min = val;
            REG_MAX_RATE:     r_max = val;
            REG_FRAME_RATE:   r_fps = val[7:0];
            REG_GAIN_VIDEO:   r_gv = val[15:0];
            REG_GAIN_SEND:    r_gs = val[15:0];
            REG_BUFFER_EN:    r_shape = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_req make_req(input logic [1:0] cmd, input logic [11:0] b,
                                      input logic [47:0] t, input logic [31:0] rr);
        t_req q;
        q.command = cmd; q.packet_bytes = b; q.now_us = t; q.reference_rate = rr;
        return q;
    endfunction

    function automatic logic [47:0] rand_time();
        case ($urandom_range(0, 3))
            0: return 48'({$urandom(), $urandom()});
            1: return TIME_MAX - 48'($urandom_range(0, 1000));
            default: return 48'($urandom_range(0, 2000000));
        endcase
    endfunction

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'hFFFF_FFFF;
            default: return $urandom_range(50000, 3000000);
        endcase
    endfunction

    // random mix of enqueues, sends, feedback and unknown commands, enqueues most often
    task automatic queue_random(input int n);
        logic [11:0] b;
        repeat (n) begin
            b = ($urandom_range(0, 4) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 1500));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: post_req(make_req(CMD_ENQ, b, rand_time(), $urandom()));
                4, 5, 6:    post_req(make_req(CMD_SEND, b, rand_time(), $urandom()));
                7, 8:       post_req(make_req(CMD_FB, b, rand_time(), rand_rate()));
                default:    post_req(make_req(CMD_UNUSED, b, rand_time(), $urandom()));
            endcase
        end
    endtask

    initial begin
        pacer_reset_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clamps, zero size, empty send, unknown command, full queue
        post_req(make_req(CMD_SEND, 0, 0, 0));
        post_req(make_req(CMD_ENQ, 12'hFFF, 100, 0));
        post_req(make_req(CMD_ENQ, 0, 200, 0));
        post_req(make_req(CMD_ENQ, 12'd1501, 300, 0));
        post_req(make_req(CMD_FB, 0, 400, 32'hFFFF_FFFF));
        post_req(make_req(CMD_FB, 0, 500, 0));
        post_req(make_req(CMD_UNUSED, 12'hAAA, 48'h5555_5555_5555, 32'h5555_5555));
        post_req(make_req(CMD_SEND, 0, TIME_MAX, 0));
        post_req(make_req(CMD_SEND, 0, 600, 0));
        post_req(make_req(CMD_SEND, 0, 700, 0));
        post_req(make_req(CMD_ENQ, 1500, 0, 0));
        repeat (QUEUE_DEPTH + 1)
            post_req(make_req(CMD_ENQ, 12'($urandom_range(0, 4095)), 0, 0));
        wait_drained();

        cfg_write(REG_FRAME_RATE, 0);
        cfg_write(REG_INITIAL_RATE, 0);
        post_req(make_req(CMD_SEND, 0, TIME_MAX - 5, 0));
        post_req(make_req(CMD_FB, 0, 1, 32'd1000));
        queue_random(60);
        wait_drained();

        cfg_write(REG_FRAME_RATE, 255);
        cfg_write(REG_GAIN_VIDEO, 16'hFFFF);
        cfg_write(REG_GAIN_SEND, 16'hFFFF);
        cfg_write(REG_MIN_RATE, 32'hFFFF_FFFF);
        cfg_write(REG_MAX_RATE, 0);
        cfg_write(REG_INITIAL_RATE, 32'hFFFF_FFFF);
        queue_random(100);
        wait_drained();

        cfg_write(REG_BUFFER_EN, 0);
        cfg_write(REG_MIN_RATE, 0);
        cfg_write(REG_MAX_RATE, 32'hFFFF_FFFF);
        cfg_write(REG_GAIN_VIDEO, 0);
        cfg_write(REG_GAIN_SEND, 0);
        // hold each request until every earlier result has come back
        hold_for_drain = 1'b1;
        queue_random(100);
        wait_drained();
        hold_for_drain = 1'b0;

        cfg_write(REG_BUFFER_EN, 1);
        cfg_write(REG_FRAME_RATE, 8'($urandom_range(1, 255)));
        cfg_write(REG_GAIN_VIDEO, 16'($urandom()));
        cfg_write(REG_GAIN_SEND, 16'($urandom()));
        cfg_write(REG_MIN_RATE, 150000);
        cfg_write(REG_MAX_RATE, 1500000);
        cfg_write(REG_INITIAL_RATE, 1000000);
        queue_random(220);
        wait_drained();

        $display("covered %0d enqueues (%0d dropped), %0d sends, %0d feedback/other requests",
                 n_enq, n_drop, n_send, n_fb);
        $display("configurations: reset defaults, zero rates, full-scale gains, bypass, random");
        if (errors == 0) begin
            $display("rate_shaping_packet_pacer verification clean");
        end else begin
            $display("rate_shaping_packet_pacer verification failed");
        end
        $finish;
    end
endmodule
